// ===== hdl/imu_dead_reckoning_2d_unit_macros.svh =====
// Assertion shorthands shared by the dead reckoning unit and its divider.
// Each expects clk and rst_n in scope.
`ifndef IMU_DEAD_RECKONING_2D_UNIT_MACROS_SVH
`define IMU_DEAD_RECKONING_2D_UNIT_MACROS_SVH

// Consequent holds in the same cycle as the antecedent.
`define IMU_DR_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define IMU_DR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/imu_dr_pkg.sv =====
`default_nettype none
package imu_dr_pkg;

    typedef logic signed [31:0] q16_t;

    typedef struct packed {
        logic signed [15:0] accel_x_raw;
        logic signed [15:0] accel_y_raw;
        logic [15:0]        elapsed_ms;
    } sample_t;

    typedef struct packed {
        q16_t position_x;
        q16_t position_y;
        q16_t velocity_x;
        q16_t velocity_y;
    } result_t;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 24;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    typedef struct packed {
        cfg_idx_t              reg_index;
        logic [CFG_DATA_W-1:0] wr_data;
    } cfg_write_t;

    localparam cfg_idx_t REG_BIAS_X          = 3'd0;
    localparam cfg_idx_t REG_BIAS_Y          = 3'd1;
    localparam cfg_idx_t REG_ACCEL_GAIN      = 3'd2;
    localparam cfg_idx_t REG_DEADBAND        = 3'd3;
    localparam cfg_idx_t REG_DRIFT_THRESHOLD = 3'd4;
    localparam cfg_idx_t REG_DRIFT_LIMIT     = 3'd5;

    localparam logic [23:0] GAIN_RESET      = 24'd10039;
    localparam logic [19:0] DEADBAND_RESET  = 20'd4588;
    localparam logic [19:0] THRESHOLD_RESET = 20'd655;
    localparam logic [7:0]  LIMIT_RESET     = 8'd10;
    localparam logic [7:0]  COUNT_MAX       = 8'hFF;

    // Shared multiplier operand and product widths
    localparam int unsigned MUL_A_W = 33;
    localparam int unsigned MUL_B_W = 25;
    localparam int unsigned PROD_W  = 49;

    // Time step divide: (x * ms) / 2000 with rounding
    localparam int unsigned TIME_DIV  = 2000;
    localparam int unsigned TIME_HALF = TIME_DIV / 2;
    localparam int unsigned REM_W     = $clog2(TIME_DIV);
    localparam int unsigned DVD_W     = 52;
    localparam int unsigned DIV_STEPS = 4;
    localparam int unsigned DIV_ITER  = DVD_W / DIV_STEPS;
    localparam int unsigned DIV_CNT_W = $clog2(DIV_ITER);
    localparam int unsigned QUO_W     = 38;

    localparam int unsigned WIDE_W = 50;

    function automatic q16_t sat32(input logic signed [WIDE_W-1:0] v);
        logic signed [WIDE_W-1:0] hi;
        logic signed [WIDE_W-1:0] lo;
        hi = WIDE_W'(64'sd2147483647);
        lo = WIDE_W'(-64'sd2147483648);
        if (v > hi)
            return 32'sh7FFF_FFFF;
        else if (v < lo)
            return 32'sh8000_0000;
        else
            return v[31:0];
    endfunction

endpackage
`default_nettype wire

// ===== hdl/imu_dr_if.sv =====
`default_nettype none
interface imu_dr_sample_if import imu_dr_pkg::*;;
    logic    valid;
    logic    ready;
    sample_t payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface imu_dr_result_if import imu_dr_pkg::*;;
    logic    valid;
    logic    ready;
    result_t payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface imu_dr_cfg_if import imu_dr_pkg::*;;
    logic       valid;
    logic       ready;
    cfg_write_t payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== hdl/imu_dead_reckoning_2d_unit.sv =====
`default_nettype none
`include "imu_dead_reckoning_2d_unit_macros.svh"
// Two-axis inertial dead reckoning. Each sample beat brings raw X and Y
// accelerometer counts and the milliseconds since the previous beat; the unit
// removes the bias, scales to Q16.16 m/s^2, zeroes values inside the deadband,
// integrates trapezoidally into velocity, forces velocity to zero once the
// per-axis drift counter passes its limit, then integrates into position, and
// returns one result beat of position and velocity (Q16.16, saturating). The
// unit works on one sample at a time and is not ready for another until its
// result is in the output register, once the previous result has been taken:
// each axis passes three times through one shared multiplier and twice
// through one shared divide-by-2000 unit that retires four quotient bits a
// cycle, and the two axes run one after the other. A finished result waits
// in the output register while the unit takes the next sample. Configuration
// is written at any time through the cfg channel, which is always ready;
// writes to indexes beyond the drift count limit are dropped.
module imu_dead_reckoning_2d_unit import imu_dr_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    imu_dr_sample_if.sink     sample,
    imu_dr_result_if.source   result,
    imu_dr_cfg_if.sink        cfg
);

    typedef enum logic [11:0] {
        ST_IDLE   = 12'b0000_0000_0001,
        ST_MUL_A  = 12'b0000_0000_0010,
        ST_ACC    = 12'b0000_0000_0100,
        ST_MUL_V  = 12'b0000_0000_1000,
        ST_DIV_V  = 12'b0000_0001_0000,
        ST_WAIT_V = 12'b0000_0010_0000,
        ST_VEL    = 12'b0000_0100_0000,
        ST_MUL_P  = 12'b0000_1000_0000,
        ST_DIV_P  = 12'b0001_0000_0000,
        ST_WAIT_P = 12'b0010_0000_0000,
        ST_POS    = 12'b0100_0000_0000,
        ST_DONE   = 12'b1000_0000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Configuration
    logic signed [15:0] bias_x_reg;
    logic signed [15:0] bias_y_reg;
    logic [23:0]        accel_gain_reg;
    logic [19:0]        deadband_reg;
    logic [19:0]        drift_threshold_reg;
    logic [7:0]         drift_count_limit_reg;

    // Per-axis state, index 0 is X, 1 is Y
    q16_t       last_accel_reg  [2];
    q16_t       speed_reg       [2];
    q16_t       place_reg       [2];
    logic [7:0] still_count_reg [2];

    // Working registers for the axis in flight
    logic    ax_reg;
    sample_t sample_reg;
    q16_t    acc_new_reg;
    q16_t    v_new_reg;
    logic    div_neg_reg;

    result_t result_reg;
    logic    result_valid_reg;
    logic    result_valid_next;
    logic    load_result;

    // Shared units
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  prod;
    logic                      div_start;
    logic [DVD_W-1:0]          div_dividend;
    logic                      div_done;
    logic [QUO_W-1:0]          div_quotient;

    // Datapath
    logic signed [15:0]  raw_sel;
    logic signed [15:0]  bias_sel;
    logic [16:0]         raw_diff;
    q16_t                a_prev;
    q16_t                v0;
    q16_t                p0;
    logic [PROD_W-1:0]   prod_mag;
    logic [PROD_W-1:0]   prod_rnd;
    logic [WIDE_W-1:0]   acc_wide;
    q16_t                acc_sat;
    logic [32:0]         acc_mag;
    q16_t                acc_next;
    logic [WIDE_W-1:0]   step_wide;
    logic [WIDE_W-1:0]   vel_sum;
    q16_t                vel_sat;
    logic [32:0]         vel_diff;
    logic [32:0]         vel_diff_mag;
    logic [7:0]          count_next;
    q16_t                v_next;
    logic [WIDE_W-1:0]   pos_sum;
    q16_t                pos_next;

    imu_dr_mul u_mul (
        .clk      (clk),
        .op_a     (mul_a),
        .op_b     (mul_b),
        .prod_reg (prod)
    );

    imu_dr_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .done     (div_done),
        .quotient (div_quotient)
    );

    assign sample.ready = (state_reg == ST_IDLE);
    assign cfg.ready    = 1'b1;
    assign result.valid   = result_valid_reg;
    assign result.payload = result_reg;

    // Sequencer: X axis then Y axis, each through the shared multiplier and divider
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (sample.valid) state_next = ST_MUL_A;
            ST_MUL_A:  state_next = ST_ACC;
            ST_ACC:    state_next = ST_MUL_V;
            ST_MUL_V:  state_next = ST_DIV_V;
            ST_DIV_V:  state_next = ST_WAIT_V;
            ST_WAIT_V: if (div_done) state_next = ST_VEL;
            ST_VEL:    state_next = ST_MUL_P;
            ST_MUL_P:  state_next = ST_DIV_P;
            ST_DIV_P:  state_next = ST_WAIT_P;
            ST_WAIT_P: if (div_done) state_next = ST_POS;
            ST_POS:    state_next = ax_reg ? ST_DONE : ST_MUL_A;
            ST_DONE:   if (load_result) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // Select the axis operands
    always_comb
    begin
        raw_sel  = ax_reg ? sample_reg.accel_y_raw : sample_reg.accel_x_raw;
        bias_sel = ax_reg ? bias_y_reg : bias_x_reg;
        raw_diff = {raw_sel[15], raw_sel} - {bias_sel[15], bias_sel};
        a_prev   = last_accel_reg[ax_reg];
        v0       = speed_reg[ax_reg];
        p0       = place_reg[ax_reg];
    end

    // Feed the multiplier: scale, then the two trapezoid sums times the time step
    always_comb
    begin
        case (state_reg)
            ST_MUL_A:
            begin
                mul_a = {{(MUL_A_W - 17){raw_diff[16]}}, raw_diff};
                mul_b = {1'b0, accel_gain_reg};
            end
            ST_MUL_V:
            begin
                mul_a = {a_prev[31], a_prev} + {acc_new_reg[31], acc_new_reg};
                mul_b = {{(MUL_B_W - 16){1'b0}}, sample_reg.elapsed_ms};
            end
            ST_MUL_P:
            begin
                mul_a = {v0[31], v0} + {v_new_reg[31], v_new_reg};
                mul_b = {{(MUL_B_W - 16){1'b0}}, sample_reg.elapsed_ms};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Magnitude of the product; sign goes back on after rounding
    assign prod_mag = prod[PROD_W-1] ? (~prod + 1'b1) : prod;

    // Acceleration: round the product by 256, saturate, apply the deadband
    always_comb
    begin
        prod_rnd = prod_mag + PROD_W'(128);
        acc_wide = {{(WIDE_W - PROD_W + 8){1'b0}}, prod_rnd[PROD_W-1:8]};
        if (prod[PROD_W-1])
            acc_wide = ~acc_wide + 1'b1;
        acc_sat  = sat32(acc_wide);
        acc_mag  = acc_sat[31] ? (~{1'b1, acc_sat} + 1'b1) : {1'b0, acc_sat};
        acc_next = (acc_mag < {13'b0, deadband_reg}) ? '0 : acc_sat;
    end

    // Divider takes |product| + 1000 so its quotient is already rounded
    assign div_start    = (state_reg == ST_DIV_V) || (state_reg == ST_DIV_P);
    assign div_dividend = {{(DVD_W - PROD_W){1'b0}}, prod_mag + PROD_W'(TIME_HALF)};

    // Velocity and position updates from the signed, rounded step
    always_comb
    begin
        step_wide = {{(WIDE_W - QUO_W){1'b0}}, div_quotient};
        if (div_neg_reg)
            step_wide = ~step_wide + 1'b1;

        vel_sum      = {{(WIDE_W - 32){v0[31]}}, v0} + step_wide;
        vel_sat      = sat32(vel_sum);
        vel_diff     = {vel_sat[31], vel_sat} - {v0[31], v0};
        vel_diff_mag = vel_diff[32] ? (~vel_diff + 1'b1) : vel_diff;
        if (vel_diff_mag < {13'b0, drift_threshold_reg})
            count_next = (still_count_reg[ax_reg] == COUNT_MAX) ? COUNT_MAX
                                                                 : still_count_reg[ax_reg] + 1'b1;
        else
            count_next = '0;
        v_next = (count_next > drift_count_limit_reg) ? '0 : vel_sat;

        pos_sum  = {{(WIDE_W - 32){p0[31]}}, p0} + step_wide;
        pos_next = sat32(pos_sum);
    end

    // Output register: load when the previous beat is gone or leaves this cycle
    always_comb
    begin
        load_result       = (state_reg == ST_DONE) && (!result_valid_reg || result.ready);
        result_valid_next = result_valid_reg;
        if (result_valid_reg && result.ready)
            result_valid_next = 1'b0;
        if (load_result)
            result_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            ax_reg           <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= result_valid_next;
            if (state_reg == ST_IDLE)
                ax_reg <= 1'b0;
            else if (state_reg == ST_POS)
                ax_reg <= 1'b1;
        end
    end

    // Configuration writes; unknown indexes drop
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bias_x_reg            <= '0;
            bias_y_reg            <= '0;
            accel_gain_reg        <= GAIN_RESET;
            deadband_reg          <= DEADBAND_RESET;
            drift_threshold_reg   <= THRESHOLD_RESET;
            drift_count_limit_reg <= LIMIT_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.payload.reg_index)
                REG_BIAS_X:          bias_x_reg            <= cfg.payload.wr_data[15:0];
                REG_BIAS_Y:          bias_y_reg            <= cfg.payload.wr_data[15:0];
                REG_ACCEL_GAIN:      accel_gain_reg        <= cfg.payload.wr_data[23:0];
                REG_DEADBAND:        deadband_reg          <= cfg.payload.wr_data[19:0];
                REG_DRIFT_THRESHOLD: drift_threshold_reg   <= cfg.payload.wr_data[19:0];
                REG_DRIFT_LIMIT:     drift_count_limit_reg <= cfg.payload.wr_data[7:0];
                default:             ;
            endcase
        end
    end

    // Axis state: counter moves at the velocity step, the rest commits at the position step
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 2; i++)
            begin
                last_accel_reg[i]  <= '0;
                speed_reg[i]       <= '0;
                place_reg[i]       <= '0;
                still_count_reg[i] <= '0;
            end
        end
        else
        begin
            if (state_reg == ST_VEL)
                still_count_reg[ax_reg] <= count_next;
            if (state_reg == ST_POS)
            begin
                last_accel_reg[ax_reg] <= acc_new_reg;
                speed_reg[ax_reg]      <= v_new_reg;
                place_reg[ax_reg]      <= pos_next;
            end
        end
    end

    // Payload holding registers
    always_ff @(posedge clk)
    begin
        if (sample.valid && sample.ready)
            sample_reg <= sample.payload;
        if (state_reg == ST_ACC)
            acc_new_reg <= acc_next;
        if (state_reg == ST_VEL)
            v_new_reg <= v_next;
        if (div_start)
            div_neg_reg <= prod[PROD_W-1];
        if (load_result)
        begin
            result_reg.position_x <= place_reg[0];
            result_reg.position_y <= place_reg[1];
            result_reg.velocity_x <= speed_reg[0];
            result_reg.velocity_y <= speed_reg[1];
        end
    end

    `IMU_DR_ASSERT_NEXT(a_accept_starts, sample.valid && sample.ready, state_reg == ST_MUL_A, "accepted beat did not start the X axis")
    `IMU_DR_ASSERT_SAME(a_done_when_waiting, div_done, state_reg == ST_WAIT_V || state_reg == ST_WAIT_P, "divider finished outside a wait state")
    `IMU_DR_ASSERT_SAME(a_result_from_done, $rose(result_valid_reg), $past(state_reg == ST_DONE), "result raised outside the done state")
    `IMU_DR_ASSERT_NEXT(a_drift_forces_zero, state_reg == ST_VEL, v_new_reg == '0 || still_count_reg[ax_reg] <= drift_count_limit_reg, "velocity kept past the drift limit")

endmodule
`default_nettype wire

// ===== hdl/imu_dr_mul.sv =====
`default_nettype none
module imu_dr_mul import imu_dr_pkg::*;
(
    input  wire logic                       clk,
    input  wire logic signed [MUL_A_W-1:0]  op_a,
    input  wire logic signed [MUL_B_W-1:0]  op_b,
    output logic signed [PROD_W-1:0]        prod_reg
);

    logic signed [MUL_A_W+MUL_B_W-1:0] full;

    assign full = op_a * op_b;

    // Operands never need more than PROD_W bits of product
    always_ff @(posedge clk)
    begin
        prod_reg <= full[PROD_W-1:0];
    end

endmodule
`default_nettype wire

// ===== hdl/imu_dr_div.sv =====
`default_nettype none
`include "imu_dead_reckoning_2d_unit_macros.svh"
module imu_dr_div import imu_dr_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [DVD_W-1:0] dividend,
    output logic                  done,
    output logic [QUO_W-1:0]      quotient
);

    localparam logic [REM_W:0]       DIVISOR  = (REM_W + 1)'(TIME_DIV);
    localparam logic [DIV_CNT_W-1:0] CNT_LAST = DIV_CNT_W'(DIV_ITER - 1);

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [REM_W-1:0]     rem_reg;
    logic [DVD_W-1:0]     dvd_reg;
    logic [REM_W:0]       step_rem;
    logic [DVD_W-1:0]     step_dvd;

    // Restoring division, DIV_STEPS quotient bits a cycle; quotient shifts in behind
    always_comb
    begin
        step_rem = {1'b0, rem_reg};
        step_dvd = dvd_reg;
        for (int i = 0; i < DIV_STEPS; i++)
        begin
            step_rem = {step_rem[REM_W-1:0], step_dvd[DVD_W-1]};
            step_dvd = {step_dvd[DVD_W-2:0], 1'b0};
            if (step_rem >= DIVISOR)
            begin
                step_rem    = step_rem - DIVISOR;
                step_dvd[0] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == CNT_LAST);
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                    busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            dvd_reg <= dividend;
        end
        else if (busy_reg)
        begin
            rem_reg <= step_rem[REM_W-1:0];
            dvd_reg <= step_dvd;
        end
    end

    assign done     = done_reg;
    assign quotient = dvd_reg[QUO_W-1:0];

    `IMU_DR_ASSERT_NEXT(a_div_start_busy, start, busy_reg, "divider did not go busy on start")
    `IMU_DR_ASSERT_SAME(a_div_done_idle, done_reg, !busy_reg, "divider done while still busy")
    `IMU_DR_ASSERT_NEXT(a_div_last_done, busy_reg && cnt_reg == CNT_LAST && !start, done_reg, "divider missed its done pulse")

endmodule
`default_nettype wire

// ===== dv/tb_imu_dead_reckoning_2d_unit.sv =====
`timescale 1ns / 100ps
`default_nettype none
// Testbench for the two-axis dead reckoning unit.
module tb_imu_dead_reckoning_2d_unit;
    import imu_dr_pkg::*;

    // Indexes past the drift count limit: the unit must drop these writes.
    localparam cfg_idx_t REG_SPARE_LO = 3'd6;
    localparam cfg_idx_t REG_SPARE_HI = 3'd7;

    // Cycles with no beat on any channel before the run is declared hung.
    localparam int unsigned QUIET_LIMIT = 5000;
    // Receiver hold-off that lets the unit fill up and stall its input.
    localparam int unsigned LONG_HOLD = 600;
    // Settling time at the end.
    localparam int unsigned TAIL_CYCLES = 150;
    localparam int unsigned MAX_REPORTS = 10;

    logic clk = 1'b0;
    logic rst_n;

    imu_dr_sample_if sample_ch ();
    imu_dr_result_if result_ch ();
    imu_dr_cfg_if    cfg_ch ();

    imu_dead_reckoning_2d_unit DUT
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Shadow copy of the unit: register file and per-axis tracking state.
    // Index 0 is the X axis, index 1 the Y axis.
    // ------------------------------------------------------------------
    logic signed [15:0] cfg_bias [2];
    logic [23:0]        cfg_gain;
    logic [19:0]        cfg_deadband;
    logic [19:0]        cfg_threshold;
    logic [7:0]         cfg_limit;

    q16_t       trail_acc [2];
    q16_t       trail_vel [2];
    q16_t       trail_pos [2];
    logic [7:0] still_cnt [2];

    sample_t sample_q [$];        // samples waiting to be offered
    result_t expected_fixes [$];  // position/velocity fixes still owed by the unit

    // Idle percentages for each side, plus a one-off receiver hold-off.
    int unsigned send_idle;
    int unsigned recv_idle;
    int unsigned recv_hold;

    int unsigned failures;
    int unsigned samples_taken;
    int unsigned fixes_checked;
    int unsigned reg_writes;
    int unsigned settings_run;
    int unsigned quiet_cycles;

    string field_names [4] = '{"position_x", "position_y", "velocity_x", "velocity_y"};

    // Divide with rounding to nearest, halves away from zero.
    function automatic longint round_div(input longint num, input longint den);
        longint mag;
        longint quo;
        mag = (num < 0) ? -num : num;
        quo = (mag + den / 2) / den;
        return (num < 0) ? -quo : quo;
    endfunction

    function automatic q16_t clamp32(input longint v);
        if (v > longint'(32'sh7FFF_FFFF))
            return 32'sh7FFF_FFFF;
        else if (v < -longint'(64'sd2147483648))
            return 32'sh8000_0000;
        else
            return q16_t'(v);
    endfunction

    // Advance both axes by one sample and return the fix the unit should give.
    task automatic dead_reckon(input sample_t s, output result_t fix);
        logic signed [15:0] raw;
        longint             ms;
        longint             scaled;
        longint             mag;
        longint             dv;
        longint             diff;
        longint             dp;
        q16_t               acc;
        q16_t               v0;
        q16_t               v;
        ms = longint'(s.elapsed_ms);
        for (int ax = 0; ax < 2; ax++)
        begin
            raw = (ax == 0) ? s.accel_x_raw : s.accel_y_raw;

            // Remove the bias, scale to Q16.16 and apply the deadband.
            scaled = round_div((longint'(raw) - longint'(cfg_bias[ax])) * longint'(cfg_gain),
                               256);
            acc = clamp32(scaled);
            mag = (acc < 0) ? -longint'(acc) : longint'(acc);
            if (mag < longint'(cfg_deadband))
                acc = '0;

            // Trapezoid into velocity.
            v0 = trail_vel[ax];
            dv = round_div((longint'(trail_acc[ax]) + longint'(acc)) * ms, 2000);
            v  = clamp32(longint'(v0) + dv);

            // Count steps of small velocity change; past the limit, pin velocity at zero.
            diff = longint'(v) - longint'(v0);
            if (diff < 0)
                diff = -diff;
            if (diff < longint'(cfg_threshold))
            begin
                if (still_cnt[ax] != COUNT_MAX)
                    still_cnt[ax] = still_cnt[ax] + 8'd1;
            end
            else
                still_cnt[ax] = '0;
            if (still_cnt[ax] > cfg_limit)
                v = '0;

            // Trapezoid into position.
            dp = round_div((longint'(v0) + longint'(v)) * ms, 2000);
            trail_pos[ax] = clamp32(longint'(trail_pos[ax]) + dp);
            trail_vel[ax] = v;
            trail_acc[ax] = acc;
        end
        fix.position_x = trail_pos[0];
        fix.position_y = trail_pos[1];
        fix.velocity_x = trail_vel[0];
        fix.velocity_y = trail_vel[1];
    endtask

    task automatic flag_failure(input string msg);
        failures++;
        if (failures <= MAX_REPORTS)
            $display("%s", msg);
    endtask

    // ------------------------------------------------------------------
    // Sample driver: offer the head of the queue, hold it until the beat
    // completes, and predict the fix at the accepting edge.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : sample_driver
        result_t fix;
        if (!rst_n)
        begin
            sample_ch.valid   <= 1'b0;
            sample_ch.payload <= '0;
        end
        else
        begin
            if (sample_ch.valid && sample_ch.ready)
            begin
                dead_reckon(sample_ch.payload, fix);
                expected_fixes.push_back(fix);
                void'(sample_q.pop_front());
                samples_taken++;
            end
            // A beat on offer but not taken stays exactly as it is.
            if (!(sample_ch.valid && !sample_ch.ready))
            begin
                if (sample_q.size() != 0 && $urandom_range(99) >= send_idle)
                begin
                    sample_ch.valid   <= 1'b1;
                    sample_ch.payload <= sample_q[0];
                end
                else
                    sample_ch.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor: check each beat against the oldest owed fix, field
    // by field, and throttle ready.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : result_monitor
        result_t got;
        result_t want;
        q16_t    got_w;
        q16_t    want_w;
        if (!rst_n)
            result_ch.ready <= 1'b0;
        else
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                got = result_ch.payload;
                if (expected_fixes.size() == 0)
                    flag_failure($sformatf("unexpected result beat: pos %0d,%0d vel %0d,%0d",
                                           got.position_x, got.position_y,
                                           got.velocity_x, got.velocity_y));
                else
                begin
                    want = expected_fixes.pop_front();
                    for (int f = 0; f < 4; f++)
                    begin
                        want_w = want[127 - 32 * f -: 32];
                        got_w  = got[127 - 32 * f -: 32];
                        if (got_w !== want_w)
                            flag_failure($sformatf("fix %0d %s: expected %0d, got %0d",
                                                   fixes_checked, field_names[f],
                                                   want_w, got_w));
                    end
                end
                fixes_checked++;
            end
            // Long hold-off first, then random back-pressure.
            if (recv_hold != 0)
            begin
                recv_hold       <= recv_hold - 1;
                result_ch.ready <= 1'b0;
            end
            else
                result_ch.ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    // Watchdog: any beat on any channel counts as progress.
    always @(posedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready))
                quiet_cycles <= 0;
            else if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("CHECK FAILED");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic sample_t mk_sample(input logic signed [15:0] x,
                                          input logic signed [15:0] y,
                                          input logic [15:0] ms);
        sample_t s;
        s.accel_x_raw = x;
        s.accel_y_raw = y;
        s.elapsed_ms  = ms;
        return s;
    endfunction

    // Still samples sit around the bias; moving ones span the whole range.
    function automatic sample_t rand_sample(input bit still);
        sample_t     s;
        int unsigned pick;
        if (still)
        begin
            s.accel_x_raw = 16'(int'(cfg_bias[0]) + int'($urandom_range(40)) - 20);
            s.accel_y_raw = 16'(int'(cfg_bias[1]) + int'($urandom_range(40)) - 20);
        end
        else
        begin
            s.accel_x_raw = 16'($urandom);
            s.accel_y_raw = 16'($urandom);
            pick = $urandom_range(99);
            if (pick < 5)
                s.accel_x_raw = 16'sh7FFF;
            else if (pick < 10)
                s.accel_y_raw = 16'sh8000;
        end
        pick = $urandom_range(99);
        if (pick < 10)
            s.elapsed_ms = '0;
        else if (pick < 75)
            s.elapsed_ms = 16'($urandom_range(20, 1));
        else if (pick < 95)
            s.elapsed_ms = 16'($urandom_range(1000, 21));
        else
            s.elapsed_ms = 16'($urandom);
        return s;
    endfunction

    // Queue bursts of motion separated by still stretches long enough
    // to trip the zero-velocity reset.
    task automatic queue_random(input int unsigned count);
        int unsigned left;
        int unsigned run;
        bit          still;
        left = count;
        while (left != 0)
        begin
            still = ($urandom_range(99) < 45);
            run   = still ? $urandom_range(30, 4) : $urandom_range(20, 1);
            if (run > left)
                run = left;
            for (int k = 0; k < run; k++)
                sample_q.push_back(rand_sample(still));
            left -= run;
        end
    endtask

    // Wait until every sample is taken and every fix has come back.
    task automatic settle();
        while (sample_q.size() != 0 || sample_ch.valid || expected_fixes.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [23:0] data);
        @(posedge clk);
        cfg_ch.valid   <= 1'b1;
        cfg_ch.payload <= cfg_write_t'{reg_index: idx, wr_data: data};
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        case (idx)
            REG_BIAS_X:          cfg_bias[0]   = data[15:0];
            REG_BIAS_Y:          cfg_bias[1]   = data[15:0];
            REG_ACCEL_GAIN:      cfg_gain      = data;
            REG_DEADBAND:        cfg_deadband  = data[19:0];
            REG_DRIFT_THRESHOLD: cfg_threshold = data[19:0];
            REG_DRIFT_LIMIT:     cfg_limit     = data[7:0];
            default: ;
        endcase
        reg_writes++;
    endtask

    // Write all six registers; junk goes in the bits above each field narrower than the data word.
    task automatic apply_setting(input logic [15:0] bx, input logic [15:0] by,
                                 input logic [23:0] gain, input logic [19:0] dband,
                                 input logic [19:0] thr, input logic [7:0] lim);
        write_reg(REG_BIAS_X, {8'($urandom), bx});
        write_reg(REG_BIAS_Y, {8'($urandom), by});
        write_reg(REG_ACCEL_GAIN, gain);
        write_reg(REG_DEADBAND, {4'($urandom), dband});
        write_reg(REG_DRIFT_THRESHOLD, {4'($urandom), thr});
        write_reg(REG_DRIFT_LIMIT, {16'($urandom), lim});
        settings_run++;
        @(negedge clk);
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        sample_ch.valid   = 1'b0;
        sample_ch.payload = '0;
        result_ch.ready   = 1'b0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.payload    = '0;
        send_idle     = 33;
        recv_idle     = 87;
        recv_hold     = 0;
        failures      = 0;
        samples_taken = 0;
        fixes_checked = 0;
        reg_writes    = 0;
        settings_run  = 1;
        quiet_cycles  = 0;

        // Shadow state starts from the reset values of the unit.
        cfg_bias[0]   = '0;
        cfg_bias[1]   = '0;
        cfg_gain      = GAIN_RESET;
        cfg_deadband  = DEADBAND_RESET;
        cfg_threshold = THRESHOLD_RESET;
        cfg_limit     = LIMIT_RESET;
        for (int ax = 0; ax < 2; ax++)
        begin
            trail_acc[ax] = '0;
            trail_vel[ax] = '0;
            trail_pos[ax] = '0;
            still_cnt[ax] = '0;
        end

        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part under reset settings: field extremes, a zero time
        // step, both sides of the deadband edge, then a still run long
        // enough to pass the drift limit and zero the velocity.
        sample_q.push_back(mk_sample(16'sd0, 16'sd0, 16'd0));
        sample_q.push_back(mk_sample(16'sh7FFF, 16'sh8000, 16'hFFFF));
        sample_q.push_back(mk_sample(16'sh7FFF, 16'sh8000, 16'hFFFF));
        sample_q.push_back(mk_sample(16'sh7FFF, 16'sh8000, 16'd0));
        sample_q.push_back(mk_sample(16'sh8000, 16'sh7FFF, 16'hFFFF));
        sample_q.push_back(mk_sample(16'sh8000, 16'sh7FFF, 16'd1));
        sample_q.push_back(mk_sample(-16'sd1, 16'sd1, 16'hFFFF));
        sample_q.push_back(mk_sample(16'sd0, 16'sd0, 16'd1000));
        sample_q.push_back(mk_sample(16'sd117, -16'sd117, 16'd10));
        sample_q.push_back(mk_sample(16'sd116, -16'sd116, 16'd10));
        sample_q.push_back(mk_sample(16'sd1, -16'sd1, 16'd1));
        for (int k = 0; k < 13; k++)
            sample_q.push_back(mk_sample(16'sd0, 16'sd0, 16'd5));
        settle();

        // Typical calibrated settings, random content.
        apply_setting(16'($urandom_range(400)) - 16'd200, 16'($urandom),
                      24'($urandom_range(40000, 1000)), 20'($urandom_range(20000)),
                      20'($urandom_range(5000)), 8'($urandom_range(30)));
        queue_random(250);
        settle();

        // Hold the receiver off while samples keep coming, so the unit
        // backs up and stalls its input; then pause until it drains.
        recv_hold = LONG_HOLD;
        queue_random(40);
        settle();

        send_idle = 87;
        recv_idle = 33;

        // Extremes: full-scale biases and gain, no deadband, no drift counting.
        apply_setting(16'h8000, 16'h7FFF, 24'hFF_FFFF, 20'd0, 20'd0, 8'd0);
        queue_random(100);
        settle();

        // Zero gain with widest deadband and threshold: the drift counter
        // climbs to full and must hold there, keeping velocity at zero.
        apply_setting(16'h0000, 16'h0000, 24'd0, 20'hF_FFFF, 20'hF_FFFF, 8'd254);
        queue_random(270);
        settle();

        // Reset-like scaling, highest limit; the spare indexes must not stick.
        apply_setting(16'($urandom), 16'($urandom_range(600)) - 16'd300, GAIN_RESET,
                      DEADBAND_RESET, 20'($urandom_range(3000)), COUNT_MAX);
        write_reg(REG_SPARE_LO, 24'($urandom));
        write_reg(REG_SPARE_HI, 24'($urandom));
        @(negedge clk);
        queue_random(200);
        settle();

        send_idle = 0;
        recv_idle = 0;

        // Full throughput with random settings.
        apply_setting(16'($urandom_range(2000)) - 16'd1000, 16'($urandom),
                      24'($urandom_range(200000)), 20'($urandom),
                      20'($urandom_range(70000)), 8'($urandom_range(15)));
        queue_random(250);
        settle();

        repeat (TAIL_CYCLES) @(posedge clk);
        if (expected_fixes.size() != 0)
            flag_failure($sformatf("%0d fixes never arrived", expected_fixes.size()));

        $display("Ran %0d samples over %0d register settings (%0d register writes).",
                 samples_taken, settings_run, reg_writes);
        $display("Checked %0d result beats; %0d failures.", fixes_checked, failures);
        if (failures == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
`default_nettype wire
